FILE: sv/pbmw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbmw_pkg
// Shared constants, types and the character decode for the packed bitmap
// window counter.
// ----------------------------------------------------------------------------
package pbmw_pkg;

  localparam int PIX              = 6;
  localparam int DEF_MAX_COLS     = 1024;
  localparam int DEF_MAX_WIN_ROWS = 64;

  localparam int CHAR_W      = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 11;
  localparam int NUM_COLS_W  = 11;
  localparam int WIN_ROWS_W  = 7;
  localparam int WIN_COLS_W  = 11;
  localparam int MAX_COUNT_W = 17;
  localparam int LANE_W      = 3;

  localparam int RST_NUM_COLS = 1024;
  localparam int RST_WIN_ROWS = 1;
  localparam int RST_WIN_COLS = 1;

  localparam int UPPER_BASE  = 10;
  localparam int LOWER_BASE  = 36;
  localparam int HASH_VALUE  = 62;
  localparam int OTHER_VALUE = 63;

  localparam logic [CHAR_W-1:0] CH_DIGIT_LO = 8'h30;
  localparam logic [CHAR_W-1:0] CH_DIGIT_HI = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UPPER_LO = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_HI = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LOWER_LO = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOWER_HI = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_HASH     = 8'h23;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_COLS = 2'd0,
    REG_WIN_ROWS = 2'd1,
    REG_WIN_COLS = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic              vld;
    logic [LANE_W-1:0] lead_lane;
    logic [LANE_W-1:0] trail_lane;
    logic              trail_en;
    logic              cmp_en;
  } sweep_iss_t;

  function automatic logic [PIX-1:0] char_value(input logic [CHAR_W-1:0] ch);
    logic [CHAR_W-1:0] v;
    if (ch >= CH_DIGIT_LO && ch <= CH_DIGIT_HI) begin
      v = ch - CH_DIGIT_LO;
    end else if (ch >= CH_UPPER_LO && ch <= CH_UPPER_HI) begin
      v = ch - CH_UPPER_LO + CHAR_W'(UPPER_BASE);
    end else if (ch >= CH_LOWER_LO && ch <= CH_LOWER_HI) begin
      v = ch - CH_LOWER_LO + CHAR_W'(LOWER_BASE);
    end else if (ch == CH_HASH) begin
      v = CHAR_W'(HASH_VALUE);
    end else begin
      v = CHAR_W'(OTHER_VALUE);
    end
    return v[PIX-1:0];
  endfunction

endpackage

FILE: sv/packed_bitmap_max_window_count.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_bitmap_max_window_count
// Largest count of set pixels in a win_rows by win_cols window of a streamed
// packed binary image.
// ----------------------------------------------------------------------------
// One character (six pixels) is taken per cycle within a row: its count word
// and stored row word are read in the cycle of the transfer and written back
// in the next. A character that ends a row stalls the input while the row is
// finished: the remaining words up to num_cols are zero-padded, a gap state
// follows, and, once the window is full and fits the row, the sliding sum
// runs over all num_cols columns, one column a cycle, and then drains. The
// result goes out at image end through an output register and may wait there
// while the next image runs.
// ----------------------------------------------------------------------------
module packed_bitmap_max_window_count #(
  parameter int MAX_COLS     = pbmw_pkg::DEF_MAX_COLS,
  parameter int MAX_WIN_ROWS = pbmw_pkg::DEF_MAX_WIN_ROWS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [pbmw_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [pbmw_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [pbmw_pkg::CHAR_W-1:0]        in_code_char,
  input  logic                               in_row_end,
  input  logic                               in_image_end,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [pbmw_pkg::MAX_COUNT_W-1:0]   out_max_count
);
  import pbmw_pkg::*;

  localparam int NW  = (MAX_COLS + PIX - 1) / PIX;
  localparam int WAW = (NW > 1) ? $clog2(NW) : 1;
  localparam int CW  = $clog2(MAX_COLS + 1);
  localparam int RW  = $clog2(MAX_WIN_ROWS + 1);
  localparam int SLW = (MAX_WIN_ROWS > 1) ? $clog2(MAX_WIN_ROWS) : 1;
  localparam int BD  = MAX_WIN_ROWS * NW;
  localparam int BAW = (BD > 1) ? $clog2(BD) : 1;
  localparam int SW  = $clog2(MAX_COLS * MAX_WIN_ROWS + 1);
  localparam int OW  = (SW > MAX_COUNT_W) ? SW : MAX_COUNT_W;
  localparam int WW  = PIX * RW;

  typedef enum logic [5:0] {
    ST_RUN   = 6'b000001,
    ST_PAD   = 6'b000010,
    ST_GAP   = 6'b000100,
    ST_SWEEP = 6'b001000,
    ST_FLUSH = 6'b010000,
    ST_FIN   = 6'b100000
  } state_t;

  function automatic logic [CW-1:0] eff_cols(input logic [NUM_COLS_W-1:0] v);
    if (v == '0) return CW'(1);
    else if (int'(v) > MAX_COLS) return CW'(MAX_COLS);
    else return CW'(v);
  endfunction

  function automatic logic [RW-1:0] eff_wrows(input logic [WIN_ROWS_W-1:0] v);
    if (v == '0) return RW'(1);
    else if (int'(v) > MAX_WIN_ROWS) return RW'(MAX_WIN_ROWS);
    else return RW'(v);
  endfunction

  function automatic logic [WIN_COLS_W-1:0] eff_wcols(input logic [WIN_COLS_W-1:0] v);
    return (v == '0) ? WIN_COLS_W'(1) : v;
  endfunction

  // configuration
  logic [CW-1:0]         ncols_r;
  logic [RW-1:0]         wrows_r;
  logic [WIN_COLS_W-1:0] wcols_r;

  // control
  state_t          state_r, state_nxt;
  logic [CW-1:0]   col_pos_r;
  logic [WAW-1:0]  word_r;
  logic [RW-1:0]   rows_seen_r;
  logic [SLW-1:0]  slot_r;
  logic [BAW-1:0]  base_r;
  logic            img_r;

  // write-back stage
  logic            p_v_r;
  logic [WAW-1:0]  p_word_r;
  logic [BAW-1:0]  p_baddr_r;
  logic [PIX-1:0]  p_bits_r;
  logic [PIX-1:0]  p_mask_r;
  logic            p_sub_r;

  // sweep pointers
  logic [CW-1:0]     j_r;
  logic [WAW-1:0]    lw_r, tw_r;
  logic [LANE_W-1:0] ll_r, tl_r;

  logic                   out_valid_r;
  logic [MAX_COUNT_W-1:0] out_max_r;

  logic            in_acc, pad_iss, iss_v, more_pad, row_fin, cfg_hit, clr_img;
  logic            out_free, out_load, sweep_go, sweep_last, sw_busy;
  logic [CW:0]     col_step;
  logic [CW-1:0]   col_adv;
  logic [PIX-1:0]  iss_mask, iss_bits;
  logic [BAW-1:0]  iss_baddr;
  logic [WAW-1:0]  cnt_raddr_a;
  logic [WW-1:0]   cnt_rd_a, cnt_rd_b, cnt_wd;
  logic [PIX-1:0]  bit_rd, bit_wd;
  logic            cnt_we;
  logic [RW-1:0]   c_lane;
  sweep_iss_t      sw_iss;
  logic [SW-1:0]   best;
  logic [OW-1:0]   best_ext;

  assign in_stall = (state_r != ST_RUN);
  assign in_acc   = in_valid && !in_stall;
  assign pad_iss  = (state_r == ST_PAD);
  assign iss_v    = in_acc || pad_iss;

  assign col_step = (CW+1)'(col_pos_r) + (CW+1)'(PIX);
  assign col_adv  = (int'(col_step) > MAX_COLS) ? CW'(MAX_COLS) : col_step[CW-1:0];
  assign more_pad = col_step < (CW+1)'(ncols_r);
  assign row_fin  = (in_acc && (in_row_end || in_image_end) && !more_pad)
                 || (pad_iss && !more_pad);

  assign cfg_hit  = cfg_we && (cfg_idx == REG_NUM_COLS || cfg_idx == REG_WIN_ROWS
                            || cfg_idx == REG_WIN_COLS);
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (state_r == ST_FIN) && img_r && out_free;
  assign clr_img  = cfg_hit || out_load;

  assign sweep_go   = (rows_seen_r == wrows_r) && (int'(wcols_r) <= int'(ncols_r));
  assign sweep_last = (j_r == ncols_r - CW'(1));

  always_comb begin
    for (int k = 0; k < PIX; k++) begin
      iss_mask[k] = ((CW+1)'(col_pos_r) + (CW+1)'(k)) < (CW+1)'(ncols_r);
    end
    iss_bits  = pad_iss ? '0 : char_value(in_code_char);
    iss_baddr = base_r + BAW'(word_r);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_RUN: begin
        if (in_acc && (in_row_end || in_image_end)) begin
          state_nxt = more_pad ? ST_PAD : ST_GAP;
        end
      end
      ST_PAD: begin
        if (!more_pad) state_nxt = ST_GAP;
      end
      ST_GAP: begin
        state_nxt = sweep_go ? ST_SWEEP : ST_FIN;
      end
      ST_SWEEP: begin
        if (sweep_last) state_nxt = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (!sw_busy) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!img_r || out_free) state_nxt = ST_RUN;
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ncols_r <= eff_cols(NUM_COLS_W'(RST_NUM_COLS));
      wrows_r <= eff_wrows(WIN_ROWS_W'(RST_WIN_ROWS));
      wcols_r <= eff_wcols(WIN_COLS_W'(RST_WIN_COLS));
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_NUM_COLS: ncols_r <= eff_cols(cfg_wdata[NUM_COLS_W-1:0]);
        REG_WIN_ROWS: wrows_r <= eff_wrows(cfg_wdata[WIN_ROWS_W-1:0]);
        REG_WIN_COLS: wcols_r <= eff_wcols(cfg_wdata[WIN_COLS_W-1:0]);
        default: ;
      endcase
    end
  end

  // row position, ring slot and sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      col_pos_r   <= '0;
      word_r      <= '0;
      rows_seen_r <= '0;
      slot_r      <= '0;
      base_r      <= '0;
      img_r       <= 1'b0;
      p_v_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      p_v_r   <= iss_v;
      if (in_acc) img_r <= in_image_end;
      if (clr_img) begin
        col_pos_r   <= '0;
        word_r      <= '0;
        rows_seen_r <= '0;
        slot_r      <= '0;
        base_r      <= '0;
      end else if (row_fin) begin
        col_pos_r <= '0;
        word_r    <= '0;
        if (rows_seen_r < wrows_r) rows_seen_r <= rows_seen_r + RW'(1);
        if (int'(slot_r) == int'(wrows_r) - 1) begin
          slot_r <= '0;
          base_r <= '0;
        end else begin
          slot_r <= slot_r + SLW'(1);
          base_r <= base_r + BAW'(NW);
        end
      end else if (iss_v) begin
        col_pos_r <= col_adv;
        if (int'(word_r) != NW - 1) word_r <= word_r + WAW'(1);
      end
    end
  end

  // capture the issued word for write-back in the next cycle
  always_ff @(posedge clk) begin
    p_word_r  <= word_r;
    p_baddr_r <= iss_baddr;
    p_bits_r  <= iss_bits;
    p_mask_r  <= iss_mask;
    p_sub_r   <= (rows_seen_r == wrows_r);
  end

  // drop the leaving row's bit, add the new one
  always_comb begin
    cnt_wd = cnt_rd_a;
    bit_wd = bit_rd;
    c_lane = '0;
    for (int k = 0; k < PIX; k++) begin
      c_lane = cnt_rd_a[k*RW +: RW];
      if (p_mask_r[k]) begin
        cnt_wd[k*RW +: RW] = c_lane - RW'(p_sub_r && bit_rd[k]) + RW'(p_bits_r[k]);
        bit_wd[k]          = p_bits_r[k];
      end
    end
  end

  assign cnt_we      = p_v_r && (p_mask_r != '0);
  assign cnt_raddr_a = (state_r == ST_SWEEP) ? lw_r : word_r;

  // sweep pointers: lead column and the column leaving the window
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      j_r  <= '0;
      lw_r <= '0;
      ll_r <= '0;
      tw_r <= '0;
      tl_r <= '0;
    end else if (state_r == ST_GAP) begin
      j_r  <= '0;
      lw_r <= '0;
      ll_r <= '0;
      tw_r <= '0;
      tl_r <= '0;
    end else if (state_r == ST_SWEEP) begin
      j_r <= j_r + CW'(1);
      if (int'(ll_r) == PIX - 1) begin
        ll_r <= '0;
        lw_r <= lw_r + WAW'(1);
      end else begin
        ll_r <= ll_r + LANE_W'(1);
      end
      if (sw_iss.trail_en) begin
        if (int'(tl_r) == PIX - 1) begin
          tl_r <= '0;
          tw_r <= tw_r + WAW'(1);
        end else begin
          tl_r <= tl_r + LANE_W'(1);
        end
      end
    end
  end

  always_comb begin
    sw_iss.vld        = (state_r == ST_SWEEP);
    sw_iss.lead_lane  = ll_r;
    sw_iss.trail_lane = tl_r;
    sw_iss.trail_en   = int'(j_r) >= int'(wcols_r);
    sw_iss.cmp_en     = int'(j_r) + 1 >= int'(wcols_r);
  end

  pbmw_count_ram #(
    .DEPTH (NW),
    .AW    (WAW),
    .DW    (WW)
  ) u_cnt (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (clr_img),
    .we      (cnt_we),
    .waddr   (p_word_r),
    .wdata   (cnt_wd),
    .raddr_a (cnt_raddr_a),
    .raddr_b (tw_r),
    .rdata_a (cnt_rd_a),
    .rdata_b (cnt_rd_b)
  );

  pbmw_bit_ram #(
    .DEPTH (BD),
    .AW    (BAW)
  ) u_bits (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (p_baddr_r),
    .wdata (bit_wd),
    .raddr (iss_baddr),
    .rdata (bit_rd)
  );

  pbmw_sweep #(
    .CNT_W (RW),
    .SUM_W (SW)
  ) u_sweep (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (state_r == ST_GAP),
    .clr_best   (clr_img),
    .iss        (sw_iss),
    .lead_word  (cnt_rd_a),
    .trail_word (cnt_rd_b),
    .best       (best),
    .busy       (sw_busy)
  );

  assign best_ext = OW'(best);

  // output register: hold until transferred
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_max_r <= best_ext[MAX_COUNT_W-1:0];
  end

  assign out_valid     = out_valid_r;
  assign out_max_count = out_max_r;

endmodule

FILE: sv/pbmw_bit_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbmw_bit_ram
// Ring of stored image rows, one word of six pixels per entry.
// ----------------------------------------------------------------------------
module pbmw_bit_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [AW-1:0]          waddr,
  input  logic [pbmw_pkg::PIX-1:0] wdata,
  input  logic [AW-1:0]          raddr,
  output logic [pbmw_pkg::PIX-1:0] rdata
);
  import pbmw_pkg::*;

  logic [PIX-1:0] mem [DEPTH];
  logic [PIX-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/pbmw_count_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbmw_count_ram
// Column counts, six columns per word, one write and two read ports.
// Per-word valid flags make a cleared word read as zero.
// ----------------------------------------------------------------------------
module pbmw_count_ram #(
  parameter int DEPTH = 171,
  parameter int AW    = 8,
  parameter int DW    = 42
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          clr,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [DW-1:0] rdata_a,
  output logic [DW-1:0] rdata_b
);

  logic [DW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [DW-1:0]    da_r, db_r;
  logic             va_r, vb_r;

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    da_r <= mem[raddr_a];
    db_r <= mem[raddr_b];
    va_r <= vld_r[raddr_a];
    vb_r <= vld_r[raddr_b];
  end

  assign rdata_a = va_r ? da_r : '0;
  assign rdata_b = vb_r ? db_r : '0;

endmodule

FILE: sv/pbmw_sweep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbmw_sweep
// Sliding horizontal sum over the column counts and the running maximum.
// ----------------------------------------------------------------------------
module pbmw_sweep #(
  parameter int CNT_W = 7,
  parameter int SUM_W = 17
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         clr_best,
  input  pbmw_pkg::sweep_iss_t         iss,
  input  logic [pbmw_pkg::PIX*CNT_W-1:0] lead_word,
  input  logic [pbmw_pkg::PIX*CNT_W-1:0] trail_word,
  output logic [SUM_W-1:0]             best,
  output logic                         busy
);
  import pbmw_pkg::*;

  sweep_iss_t       iss_r;
  logic             cmp_r;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [SUM_W-1:0] best_r;
  logic [CNT_W-1:0] cnt_new, cnt_old;

  always_comb begin
    cnt_new = lead_word[iss_r.lead_lane*CNT_W +: CNT_W];
    cnt_old = iss_r.trail_en ? trail_word[iss_r.trail_lane*CNT_W +: CNT_W] : '0;
    sum_nxt = sum_r + SUM_W'(cnt_new) - SUM_W'(cnt_old);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_r  <= '0;
      cmp_r  <= 1'b0;
      sum_r  <= '0;
      best_r <= '0;
    end else begin
      iss_r <= iss;
      cmp_r <= iss_r.vld && iss_r.cmp_en;
      if (start) begin
        sum_r <= '0;
      end else if (iss_r.vld) begin
        sum_r <= sum_nxt;
      end
      if (clr_best) begin
        best_r <= '0;
      end else if (cmp_r && sum_r > best_r) begin
        best_r <= sum_r;
      end
    end
  end

  assign best = best_r;
  assign busy = iss_r.vld || cmp_r;

endmodule

FILE: sv/pbmw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbmw_checker
// Port-level checks for the packed bitmap window counter.
// ----------------------------------------------------------------------------
module pbmw_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             cfg_we,
  input logic [pbmw_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input logic [pbmw_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic [pbmw_pkg::CHAR_W-1:0]      in_code_char,
  input logic                             in_row_end,
  input logic                             in_image_end,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [pbmw_pkg::MAX_COUNT_W-1:0] out_max_count
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_max_count))
    else $error("result changed while stalled");

  // a row-ending transfer is always followed by a stall
  a_row_end_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_row_end || in_image_end) |=> in_stall)
    else $error("input taken straight after row end");

  // a new result only appears after a finishing phase
  a_out_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without row finish");

endmodule

bind packed_bitmap_max_window_count pbmw_checker u_pbmw_checker (.*);

FILE: tb/packed_bitmap_max_window_count_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_bitmap_max_window_count_tb
// Self-checking bench for the sliding-window pixel count of a packed image.
// A short stimulus table covers the character classes, register limits and
// the window that does not fit. Random images over many register settings
// follow. A predictor in the bench tracks the row ring, column counts and best window;
// each max_count transfer is checked against it or against a value in the table.
// ----------------------------------------------------------------------------
module packed_bitmap_max_window_count_tb;
  import pbmw_pkg::*;

  localparam int NCOLS = 1024;
  localparam int NWROWS = 64;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_idx;
  logic [CFG_DATA_W-1:0]  cfg_wdata;
  logic                   in_valid;
  logic                   in_stall;
  logic [CHAR_W-1:0]      in_code_char;
  logic                   in_row_end;
  logic                   in_image_end;
  logic                   out_valid;
  logic                   out_stall;
  logic [MAX_COUNT_W-1:0] out_max_count;

  packed_bitmap_max_window_count dut (.*);

  // Predictor state
  int unsigned pr_ncols, pr_wrows, pr_wcols;
  bit          ring_bits[NWROWS][NCOLS];
  int unsigned col_cnt[NCOLS];
  int unsigned best, seen, col_pos, slot;

  logic [MAX_COUNT_W-1:0] max_count_q[$];
  int errors;
  bit calm;
  bit typed_chk;
  logic [MAX_COUNT_W-1:0] typed_val;

  typedef struct {
    bit               is_cfg;
    cfg_reg_t         idx;
    logic [10:0]      data;
    logic [7:0]       ch;
    bit               re;
    bit               ie;
    bit               chk;
    int               val;
  } stim_row_t;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic int unsigned eff_cols();
    if (pr_ncols == 0) return 1;
    return (pr_ncols > NCOLS) ? NCOLS : pr_ncols;
  endfunction

  function automatic int unsigned eff_wrows();
    if (pr_wrows == 0) return 1;
    return (pr_wrows > NWROWS) ? NWROWS : pr_wrows;
  endfunction

  function automatic int unsigned eff_wcols();
    return (pr_wcols == 0) ? 1 : pr_wcols;
  endfunction

  function automatic logic [5:0] decode_char(logic [7:0] ch);
    if (ch >= "0" && ch <= "9") return 6'(ch - "0");
    if (ch >= "A" && ch <= "Z") return 6'(ch - "A" + 10);
    if (ch >= "a" && ch <= "z") return 6'(ch - "a" + 36);
    if (ch == "#") return 6'd62;
    return 6'd63;
  endfunction

  function automatic void clear_image();
    foreach (col_cnt[j]) col_cnt[j] = 0;
    best = 0;
    seen = 0;
    col_pos = 0;
    slot = 0;
  endfunction

  function automatic void put_pixel(int unsigned col, bit b);
    if (col >= eff_cols()) return;
    if (seen >= eff_wrows()) col_cnt[col] -= ring_bits[slot][col];
    ring_bits[slot][col] = b;
    col_cnt[col] += b;
  endfunction

  function automatic void close_row();
    int unsigned nc, wr, wc, sum;
    nc = eff_cols();
    wr = eff_wrows();
    wc = eff_wcols();
    for (int unsigned j = col_pos; j < nc; j++) put_pixel(j, 1'b0);
    if (seen < wr) seen++;
    slot = (slot + 1) % wr;
    col_pos = 0;
    if (seen == wr && wc <= nc) begin
      sum = 0;
      for (int unsigned j = 0; j < nc; j++) begin
        sum += col_cnt[j];
        if (j >= wc) sum -= col_cnt[j - wc];
        if (j + 1 >= wc && sum > best) best = sum;
      end
    end
  endfunction

  // Advance the predictor by one character; returns 1 when a result is due.
  function automatic bit predict_char(logic [7:0] ch, bit re, bit ie,
                                      output logic [MAX_COUNT_W-1:0] res);
    logic [5:0] v;
    v = decode_char(ch);
    res = '0;
    for (int k = 0; k < PIX; k++) put_pixel(col_pos + k, v[k]);
    col_pos += PIX;
    if (col_pos > NCOLS) col_pos = NCOLS;
    if (re || ie) close_row();
    if (ie) begin
      res = best[MAX_COUNT_W-1:0];
      clear_image();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Input side: accept transfers and queue the expected max_count.
  always @(posedge clk) begin
    logic [MAX_COUNT_W-1:0] res;
    if (rst_n && in_valid && !in_stall) begin
      if (predict_char(in_code_char, in_row_end, in_image_end, res))
        max_count_q.push_back(typed_chk ? typed_val : res);
    end
  end

  // Result side
  always @(posedge clk) begin
    logic [MAX_COUNT_W-1:0] exp_val;
    if (rst_n && out_valid && !out_stall) begin
      if (max_count_q.size() == 0) begin
        $error("unexpected result: max_count %0d", out_max_count);
        errors++;
      end else begin
        exp_val = max_count_q.pop_front();
        if (out_max_count !== exp_val) begin
          $error("max_count mismatch: expected %0d, actual %0d", exp_val, out_max_count);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= rst_n && !calm && ($urandom_range(99) < 25);
  end

  task automatic write_reg(cfg_reg_t idx, logic [10:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    // Only the three listed registers exist; they clear the image.
    case (idx)
      REG_NUM_COLS: begin pr_ncols = data; clear_image(); end
      REG_WIN_ROWS: begin pr_wrows = data[6:0]; clear_image(); end
      REG_WIN_COLS: begin pr_wcols = data; clear_image(); end
      default: ;
    endcase
  endtask

  // Valid stays high after a transfer so that the next character can follow
  // straight away; an idle cycle or drain() drops it.
  task automatic send_char(logic [7:0] ch, bit re, bit ie, bit chk = 0, int val = 0);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    typed_chk    = chk;
    typed_val    = MAX_COUNT_W'(val);
    in_valid     <= 1'b1;
    in_code_char <= ch;
    in_row_end   <= re;
    in_image_end <= ie;
    do @(posedge clk); while (in_stall);
  endtask

  // Hold off until every result is in, then let a row's worth of work drain.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (max_count_q.size() != 0) @(posedge clk);
    repeat (3 * eff_cols() + 300) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_char();
    case ($urandom_range(5))
      0: return 8'("0" + $urandom_range(9));
      1: return 8'("A" + $urandom_range(25));
      2: return 8'("a" + $urandom_range(25));
      3: return "#";
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  stim_row_t table_rows[] = '{
    '{0, REG_NUM_COLS, 0, "0", 0, 1, 1, 0},
    '{0, REG_NUM_COLS, 0, 8'hFF, 0, 1, 1, 1},
    '{0, REG_NUM_COLS, 0, "#", 0, 1, 1, 1},
    '{0, REG_NUM_COLS, 0, "z", 0, 1, 1, 1},
    '{0, REG_NUM_COLS, 0, "9", 1, 0, 0, 0},
    '{0, REG_NUM_COLS, 0, "A", 0, 0, 0, 0},
    '{0, REG_NUM_COLS, 0, "Z", 1, 0, 0, 0},
    '{0, REG_NUM_COLS, 0, "a", 0, 1, 1, 1},
    '{1, REG_NUM_COLS, 0, 0, 0, 0, 0, 0},
    '{0, REG_NUM_COLS, 0, 8'h00, 0, 1, 1, 1},
    '{1, REG_NUM_COLS, 12, 0, 0, 0, 0, 0},
    '{1, REG_WIN_ROWS, 127, 0, 0, 0, 0, 0},
    '{1, REG_WIN_COLS, 2047, 0, 0, 0, 0, 0},
    '{0, REG_NUM_COLS, 0, 8'hFF, 1, 0, 0, 0},
    '{0, REG_NUM_COLS, 0, 8'hFF, 0, 1, 1, 0},
    '{1, REG_WIN_ROWS, 0, 0, 0, 0, 0, 0},
    '{1, REG_WIN_COLS, 0, 0, 0, 0, 0, 0},
    '{1, cfg_reg_t'(2'd3), 11'h7FF, 0, 0, 0, 0, 0},
    '{0, REG_NUM_COLS, 0, "Y", 0, 0, 0, 0},
    '{0, REG_NUM_COLS, 0, 8'h80, 0, 0, 0, 0},
    '{0, REG_NUM_COLS, 0, "1", 0, 1, 0, 0},
    '{1, REG_WIN_COLS, 12, 0, 0, 0, 0, 0},
    '{0, REG_NUM_COLS, 0, 8'hFF, 0, 0, 0, 0},
    '{0, REG_NUM_COLS, 0, 8'hFF, 0, 1, 1, 12}
  };

  initial begin
    int unsigned items, nrows, nchars, nimg;
    bit partial;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = REG_NUM_COLS;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_code_char = '0;
    in_row_end = 1'b0;
    in_image_end = 1'b0;
    typed_chk = 1'b0;
    typed_val = '0;
    errors = 0;
    calm = 1'b0;
    pr_ncols = RST_NUM_COLS;
    pr_wrows = RST_WIN_ROWS;
    pr_wcols = RST_WIN_COLS;
    clear_image();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (table_rows[i]) begin
      if (table_rows[i].is_cfg) begin
        drain();
        write_reg(table_rows[i].idx, table_rows[i].data);
      end else begin
        send_char(table_rows[i].ch, table_rows[i].re, table_rows[i].ie,
                  table_rows[i].chk, table_rows[i].val);
      end
    end
    typed_chk = 1'b0;

    items = 0;
    while (items < 900) begin
      drain();
      calm = (items >= 400 && items < 550);
      if ($urandom_range(15) == 0) begin
        write_reg(REG_NUM_COLS, ($urandom_range(1)) ? 11'd1024 : 11'h7FF);
        write_reg(REG_WIN_ROWS, 11'($urandom_range(1, 3)));
        write_reg(REG_WIN_COLS, $urandom_range(1) ? 11'd1024
                                                  : 11'($urandom_range(1, 40)));
      end else begin
        write_reg(REG_NUM_COLS, 11'($urandom_range(0, 48)));
        write_reg(REG_WIN_ROWS, ($urandom_range(7) == 0) ? 11'($urandom_range(60, 127))
                                                         : 11'($urandom_range(0, 5)));
        write_reg(REG_WIN_COLS, 11'($urandom_range(0, eff_cols() + 3)));
      end
      nimg = $urandom_range(1, 3);
      partial = ($urandom_range(4) == 0);
      for (int unsigned im = 0; im < nimg; im++) begin
        nrows = (eff_cols() > 100) ? $urandom_range(1, 3)
                                   : $urandom_range(1, eff_wrows() + 3);
        for (int unsigned r = 0; r < nrows; r++) begin
          nchars = (eff_cols() > 100 && $urandom_range(1)) ? (eff_cols() + 5) / 6
                 : $urandom_range(1, (eff_cols() > 100 ? 20 : (eff_cols() + 5) / 6 + 2));
          for (int unsigned c = 0; c < nchars; c++) begin
            bit last_c, ie, re;
            last_c = (c == nchars - 1);
            ie = last_c && (r == nrows - 1) && !(partial && im == nimg - 1);
            // Image end sometimes stands without row end.
            re = last_c && !(ie && $urandom_range(1));
            if (partial && im == nimg - 1 && r == nrows - 1) re = 1'b0;
            send_char(rand_char(), re, ie);
            items++;
          end
        end
      end
    end

    calm = 1'b0;
    drain();
    if (errors == 0 && max_count_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/pbmw_pkg.sv
sv/pbmw_bit_ram.sv
sv/pbmw_count_ram.sv
sv/pbmw_sweep.sv
sv/packed_bitmap_max_window_count.sv
sv/pbmw_checker.sv
tb/packed_bitmap_max_window_count_tb.sv
